### sv/nidg_pkg.sv
// nidg_pkg: types, lookup tables and helpers for the NAND ID geometry decoder.
// Used by nidg_derive and nand_id_geometry_decode_unit. No dependencies.
`timescale 1ns / 1ps

package nidg_pkg;

   localparam int unsigned PartCount = 13;
   localparam int unsigned DevCount  = 14;

   localparam logic [7:0] MakerEc    = 8'hEC;
   localparam logic [7:0] MakerAd    = 8'hAD;
   localparam logic [7:0] MakerFix   = 8'h01;
   localparam logic [7:0] CellMcMask = 8'h0C;
   localparam logic [2:0] CodeUndef  = 3'd7;

   // 768 KiB erase block, the only block size that is not a power of two
   localparam logic [24:0] Block768k = 25'd786432;

   localparam logic [9:0] SpareEcc23 = 10'd64;
   localparam logic [9:0] SpareEcc42 = 10'd128;
   localparam logic [10:0] EccSegBytes = 11'd1024;
   localparam logic [5:0]  EccCode23   = 6'd23;
   localparam logic [5:0]  EccCode42   = 6'd42;

   typedef enum logic [1:0] {
      DEV_GENERIC = 2'd0,  // page size comes from the extended ID byte
      DEV_SMALL   = 2'd1,  // fixed 512-byte page, 16 KiB block unless blk_fix
      DEV_LARGE   = 2'd2   // fixed 2048-byte page, 16 KiB block
   } dev_kind_type;

   // exact-match part table: maker, bytes 1..4, page/chip/block sizes as log2 values, spare in bytes
   localparam logic [7:0] PartMaker [PartCount] = '{
      8'h98, 8'hEC, 8'hEC, 8'hAD, 8'h98, 8'h98, 8'h98,
      8'hEF, 8'hF8, 8'h2C, 8'hC8, 8'h98, 8'hF8};
   localparam logic [31:0] PartId [PartCount] = '{
      32'hF18015F2, 32'hF1009540, 32'hF1009541, 32'hF1801DAD, 32'hD1901576,
      32'hF1801572, 32'hDA901576, 32'hF1809500, 32'hF1809500, 32'hDA909506,
      32'hF1801D42, 32'hDC902676, 32'hDC909546};
   localparam logic [3:0] PartPageExp [PartCount] = '{
      4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
      4'd11, 4'd11, 4'd11, 4'd11, 4'd12, 4'd11};
   localparam logic [5:0] PartChipExp [PartCount] = '{
      6'd27, 6'd27, 6'd27, 6'd27, 6'd27, 6'd27, 6'd28,
      6'd27, 6'd27, 6'd28, 6'd27, 6'd29, 6'd29};
   localparam logic [4:0] PartBlkExp [PartCount] = '{
      5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17,
      5'd17, 5'd17, 5'd17, 5'd17, 5'd18, 5'd17};
   localparam logic [9:0] PartSpare [PartCount] = '{
      10'd64, 10'd64, 10'd64, 10'd64, 10'd64, 10'd128, 10'd128,
      10'd64, 10'd64, 10'd128, 10'd128, 10'd256, 10'd128};

   // device-code table: code, chip size (log2 bytes), page/block kind
   localparam logic [7:0] DevCode [DevCount] = '{
      8'h76, 8'h79, 8'h71, 8'hF2, 8'hD0, 8'hF1, 8'hD1,
      8'hDA, 8'hDC, 8'hD3, 8'hD5, 8'hD7, 8'hDE, 8'h01};
   localparam logic [5:0] DevChipExp [DevCount] = '{
      6'd26, 6'd27, 6'd28, 6'd26, 6'd26, 6'd27, 6'd27,
      6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd27};
   localparam dev_kind_type DevKind [DevCount] = '{
      DEV_SMALL, DEV_SMALL, DEV_SMALL, DEV_GENERIC, DEV_GENERIC, DEV_GENERIC,
      DEV_GENERIC, DEV_GENERIC, DEV_GENERIC, DEV_GENERIC, DEV_GENERIC,
      DEV_GENERIC, DEV_GENERIC, DEV_LARGE};

   // spare bytes by 3-bit spare code of the six-byte extended IDs
   localparam logic [9:0] SpareEc [8] = '{
      10'd640, 10'd128, 10'd218, 10'd400, 10'd436, 10'd640, 10'd640, 10'd640};
   localparam logic [9:0] SpareAd [8] = '{
      10'd128, 10'd224, 10'd448, 10'd64, 10'd32, 10'd16, 10'd640, 10'd0};

   // stage 1 -> stage 2: table lookups and ID checks
   typedef struct packed {
      logic       part_hit;
      logic [3:0] part_idx;
      logic       dev_hit;
      logic [3:0] dev_idx;
      logic       six_byte;
      logic       maker_ec;
      logic       maker_ad;
      logic       blk_fix;
      logic [7:0] ext;
   } lookup_type;

   // stage 2 -> stage 3: geometry as exponents
   typedef struct packed {
      logic       ok;
      logic [3:0] page_exp;
      logic [4:0] blk_exp;
      logic       blk_768;
      logic [5:0] chip_exp;
      logic [9:0] spare;
   } geom_type;

   typedef struct packed {
      logic        supported;
      logic [14:0] page_bytes;
      logic [9:0]  spare_bytes;
      logic [24:0] block_bytes;
      logic [33:0] chip_bytes;
      logic [2:0]  column_cycles;
      logic [2:0]  row_cycles;
      logic [14:0] pages_per_block;
      logic [17:0] block_count;
      logic [10:0] ecc_segment_bytes;
      logic [5:0]  ecc_code_bytes;
   } result_type;

   // floor(chip / 768 KiB) for chip = 2**chip_exp
   function automatic logic [17:0] blocks_768k(input logic [5:0] chip_exp);
      logic [17:0] n;
      begin
         case (chip_exp)
            6'd26:   n = 18'd85;
            6'd27:   n = 18'd170;
            6'd28:   n = 18'd341;
            6'd29:   n = 18'd682;
            6'd30:   n = 18'd1365;
            6'd31:   n = 18'd2730;
            6'd32:   n = 18'd5461;
            6'd33:   n = 18'd10922;
            default: n = '0;
         endcase
         return n;
      end
   endfunction

endpackage

### sv/nidg_derive.sv
// nidg_derive: expands the exponent-form geometry into byte counts, address
// cycles, block counts and ECC sizes. Combinational. Depends on nidg_pkg.
`timescale 1ns / 1ps

module nidg_derive import nidg_pkg::*; (
   input  geom_type   geom,
   output result_type res
);

   logic [5:0] row_span;
   logic [4:0] ppb_shift;
   logic [5:0] cnt_shift;

   assign row_span  = geom.chip_exp - {2'b00, geom.page_exp};
   assign ppb_shift = geom.blk_768 ? (5'd18 - {1'b0, geom.page_exp})
                                   : (geom.blk_exp - {1'b0, geom.page_exp});
   assign cnt_shift = geom.chip_exp - {1'b0, geom.blk_exp};

   always_comb begin
      res = '0;
      if (geom.ok) begin
         res.supported   = 1'b1;
         res.page_bytes  = 15'd1 << geom.page_exp;
         res.spare_bytes = geom.spare;
         res.block_bytes = geom.blk_768 ? Block768k : (25'd1 << geom.blk_exp);
         res.chip_bytes  = 34'd1 << geom.chip_exp;
         // 512-byte pages use one column cycle
         res.column_cycles = (geom.page_exp == 4'd9) ? 3'd1
                                                     : 3'((geom.page_exp >> 3) + 4'd1);
         // bytes needed for (pages - 1) = 2**row_span - 1
         res.row_cycles = 3'((row_span + 6'd7) >> 3);
         res.pages_per_block = geom.blk_768 ? (15'd3 << ppb_shift) : (15'd1 << ppb_shift);
         res.block_count = geom.blk_768 ? blocks_768k(geom.chip_exp)
                                        : (18'd1 << cnt_shift);
         if (geom.spare == SpareEcc23) begin
            res.ecc_segment_bytes = EccSegBytes;
            res.ecc_code_bytes    = EccCode23;
         end else if (geom.spare >= SpareEcc42) begin
            res.ecc_segment_bytes = EccSegBytes;
            res.ecc_code_bytes    = EccCode42;
         end
      end
   end

endmodule

### sv/nand_id_geometry_decode_unit.sv
// nand_id_geometry_decode_unit: NAND READ ID to geometry decoder, top level.
// Depends on nidg_pkg and nidg_derive.
`timescale 1ns / 1ps
//
//  Channel | Direction | Ports                         | Transaction
//  --------+-----------+-------------------------------+--------------------------
//  req     | in        | req_tvalid/tready/tdata[63:0] | eight READ ID bytes
//  rsp     | out       | rsp_tvalid/tready/tdata[143:0]| decoded geometry
//          |           | rsp_tuser[0]                  | supported flag
//
//  Three register stages: a request passes stage 1, stage 2 and stage 3 before
//  rsp_tvalid rises; one transaction per cycle sustained while rsp_tready is high.
//  Stages: table/ID compares, geometry decode into exponents, expansion into
//  byte counts and derived fields (registered output).
//  Each stage holds while the one after it is full and stalled; bubbles close up,
//  so req_tready stays high while any stage is empty.
//  reset (synchronous, active high) clears the stage valid bits only.

module nand_id_geometry_decode_unit import nidg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] maker_code, [15:8] device_code, [23:16] cell_info, [31:24] ext_info,
   // [39:32] id_byte_four, [47:40] id_byte_five, [55:48] id_byte_six,
   // [63:56] id_byte_seven
   input  logic [63:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [14:0] page_bytes, [24:15] spare_bytes, [49:25] block_bytes,
   // [83:50] chip_bytes, [86:84] column_cycles, [89:87] row_cycles,
   // [104:90] pages_per_block, [122:105] block_count,
   // [133:123] ecc_segment_bytes, [139:134] ecc_code_bytes, [143:140] zero
   output logic [143:0] rsp_tdata,
   // [0] supported
   output logic [0:0]   rsp_tuser
);

   logic [7:0] maker_code, device_code, cell_info, ext_info;
   logic [7:0] id_byte_four, id_byte_five, id_byte_six, id_byte_seven;
   logic [31:0] id_word;

   assign maker_code    = req_tdata[7:0];
   assign device_code   = req_tdata[15:8];
   assign cell_info     = req_tdata[23:16];
   assign ext_info      = req_tdata[31:24];
   assign id_byte_four  = req_tdata[39:32];
   assign id_byte_five  = req_tdata[47:40];
   assign id_byte_six   = req_tdata[55:48];
   assign id_byte_seven = req_tdata[63:56];
   assign id_word = {device_code, cell_info, ext_info, id_byte_four};

   // ---------------- stage control ----------------
   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;

   assign adv3 = !v3_ff || rsp_tready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // ---------------- stage 1: lookups ----------------
   lookup_type s1_in, s1_ff;

   always_comb begin
      s1_in = '0;
      // first match wins, so scan from the end and let earlier entries overwrite
      for (int i = PartCount - 1; i >= 0; i--) begin
         if (maker_code == PartMaker[i] && id_word == PartId[i]) begin
            s1_in.part_hit = 1'b1;
            s1_in.part_idx = 4'(i);
         end
      end
      for (int i = DevCount - 1; i >= 0; i--) begin
         if (device_code == DevCode[i]) begin
            s1_in.dev_hit = 1'b1;
            s1_in.dev_idx = 4'(i);
         end
      end
      // six-byte ID: wraparound bytes repeat the first two, multichip bits set, byte five nonzero
      s1_in.six_byte = (maker_code == id_byte_six) && (device_code == id_byte_seven) &&
                       ((cell_info & CellMcMask) != 8'd0) && (id_byte_five != 8'd0);
      s1_in.maker_ec = (maker_code == MakerEc);
      s1_in.maker_ad = (maker_code == MakerAd);
      // legacy block-size fix of maker 0x01: bytes 5 to 7 zero with byte 4 set
      s1_in.blk_fix  = (maker_code == MakerFix) && (id_byte_four != 8'd0) &&
                       (id_byte_five == 8'd0) && (id_byte_six == 8'd0) &&
                       (id_byte_seven == 8'd0);
      s1_in.ext      = ext_info;
   end

   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= s1_in;
   end

   // ---------------- stage 2: geometry decode ----------------
   geom_type s2_in, s2_ff;
   logic [2:0] spare_code, blk_code;
   dev_kind_type dev_kind;

   assign spare_code = {s1_ff.ext[6], s1_ff.ext[3:2]};
   assign blk_code   = {s1_ff.ext[7], s1_ff.ext[5:4]};
   assign dev_kind   = DevKind[s1_ff.dev_idx];

   always_comb begin
      s2_in = '0;
      if (s1_ff.part_hit) begin
         s2_in.ok       = 1'b1;
         s2_in.page_exp = PartPageExp[s1_ff.part_idx];
         s2_in.chip_exp = PartChipExp[s1_ff.part_idx];
         s2_in.blk_exp  = PartBlkExp[s1_ff.part_idx];
         s2_in.spare    = PartSpare[s1_ff.part_idx];
      end else if (s1_ff.dev_hit) begin
         s2_in.ok       = 1'b1;
         s2_in.chip_exp = DevChipExp[s1_ff.dev_idx];
         case (dev_kind)
            DEV_GENERIC: begin
               if (s1_ff.six_byte && s1_ff.maker_ec) begin
                  s2_in.page_exp = 4'd11 + {2'b00, s1_ff.ext[1:0]};
                  s2_in.spare    = SpareEc[spare_code];
                  s2_in.blk_exp  = 5'd17 + {2'b00, blk_code};
               end else if (s1_ff.six_byte && s1_ff.maker_ad) begin
                  if (spare_code == CodeUndef || blk_code == CodeUndef) begin
                     s2_in = '0;
                  end else begin
                     s2_in.page_exp = 4'd11 + {2'b00, s1_ff.ext[1:0]};
                     s2_in.spare    = SpareAd[spare_code];
                     case (blk_code)
                        3'd0, 3'd1, 3'd2: s2_in.blk_exp = 5'd17 + {2'b00, blk_code};
                        3'd3:             s2_in.blk_768 = 1'b1;
                        default:          s2_in.blk_exp = 5'd16 + {2'b00, blk_code};
                     endcase
                  end
               end else begin
                  s2_in.page_exp = 4'd10 + {2'b00, s1_ff.ext[1:0]};
                  // (8 or 16) * page / 512
                  s2_in.spare    = 10'd1 << ({2'b00, s1_ff.ext[1:0]} +
                                             {3'b000, s1_ff.ext[2]} + 4'd4);
                  s2_in.blk_exp  = 5'd16 + {3'b000, s1_ff.ext[5:4]};
               end
            end
            DEV_SMALL: begin
               s2_in.page_exp = 4'd9;
               s2_in.spare    = 10'd16;
               s2_in.blk_exp  = s1_ff.blk_fix ? (5'd17 + {2'b00, s1_ff.ext[1:0], 1'b0})
                                              : 5'd14;
            end
            DEV_LARGE: begin
               s2_in.page_exp = 4'd11;
               s2_in.spare    = 10'd64;
               s2_in.blk_exp  = 5'd14;
            end
            default: s2_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) s2_ff <= s2_in;
   end

   // ---------------- stage 3: derived fields ----------------
   result_type s3_in, s3_ff;

   nidg_derive u_derive (
      .geom (s2_ff),
      .res  (s3_in)
   );

   always_ff @(posedge clock) begin
      if (adv3) s3_ff <= s3_in;
   end

   assign rsp_tvalid   = v3_ff;
   assign rsp_tuser[0] = s3_ff.supported;
   assign rsp_tdata = {4'b0000,
                       s3_ff.ecc_code_bytes,
                       s3_ff.ecc_segment_bytes,
                       s3_ff.block_count,
                       s3_ff.pages_per_block,
                       s3_ff.row_cycles,
                       s3_ff.column_cycles,
                       s3_ff.chip_bytes,
                       s3_ff.block_bytes,
                       s3_ff.spare_bytes,
                       s3_ff.page_bytes};

   // ---------------- assertions ----------------
   // an unsupported ID carries an all-zero geometry
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("unsupported result with nonzero geometry");

   // page and chip sizes of a decoded part are single powers of two
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> $onehot(rsp_tdata[14:0]) && $onehot(rsp_tdata[83:50]))
      else $error("page or chip size not a power of two");

   // ECC segment and code sizes are both set or both clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[133:123] == '0) == (rsp_tdata[139:134] == '0)))
      else $error("inconsistent ECC sizes");

   // into an empty pipe, a transaction passes the three register stages to the output
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !v1_ff && !v2_ff && !v3_ff |-> ##3 rsp_tvalid)
      else $error("pipeline latency mismatch");

endmodule
